### sv/tst_pkg.sv
// ----------------------------------------------------------------------------
// tst_pkg: shared types and constants
// Command codes, slot record layout and packed widths for the table unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tst_pkg;

    // bucket count; a power of two so the bucket index wraps by truncation
    localparam int TABLE_BUCKETS = 4096;

    localparam logic [2:0] CMD_LOOKUP    = 3'd0;
    localparam logic [2:0] CMD_UPDATE    = 3'd1;
    localparam logic [2:0] CMD_CLEAR     = 3'd2;
    localparam logic [2:0] CMD_RST_MID   = 3'd3;
    localparam logic [2:0] CMD_RST_WL    = 3'd4;
    localparam logic [2:0] CMD_RST_EXACT = 3'd5;

    localparam logic [1:0] CFG_ENABLE = 2'd0;
    localparam logic [1:0] CFG_INF    = 2'd1;
    localparam logic [1:0] CFG_MID_LO = 2'd2;
    localparam logic [1:0] CFG_MID_HI = 2'd3;

    localparam logic [6:0] EXACT_EMPTIES = 7'd59;

    typedef struct packed {
        logic [63:0]        black;
        logic [63:0]        white;
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        logic signed [7:0]  move;
        logic [6:0]         empties;
    } t_slot;

    localparam int SLOT_W   = $bits(t_slot);
    localparam int BUCKET_W = 2 * SLOT_W;

    typedef struct packed {
        logic [2:0]         command;
        logic [63:0]        black;
        logic [63:0]        white;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic signed [31:0] score;
        logic [6:0]         empties;
        logic signed [7:0]  move;
    } t_req;

    // in tdata: 3+12+64+64+32*3+7+8 = 254 -> 256
    localparam int IN_W  = 256;
    // out tdata: 1+1+32+32+8+7 = 81 -> 88
    localparam int OUT_W = 88;

endpackage

`default_nettype wire

### sv/two_slot_transposition_table_unit.sv
// ----------------------------------------------------------------------------
// two_slot_transposition_table_unit: two-slot transposition table
// Lookup/update: address capture, RAM read, write-back, then the result is offered.
// Bulk commands (clear, bound resets) sweep one bucket per cycle. One request
// is in flight; the next is accepted in the cycle after the result is taken.
// After reset a clearing pass zeroes every bucket before any request
// is accepted; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
`default_nettype none

module two_slot_transposition_table_unit (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // command, bucket_index, black_bits, white_bits, alpha_bound, beta_bound,
    // search_score, empty_squares, best_move, zero pad
    input  wire [255:0]  s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // found, found_slot, lower_bound, upper_bound, stored_move, stored_depth, pad
    output logic [87:0]  m_axis_tdata,
    input  wire          i_cfg_we,
    input  wire [1:0]    i_cfg_index,
    input  wire [31:0]   i_cfg_data
);
    import tst_pkg::*;

    localparam int AW = (TABLE_BUCKETS > 1) ? $clog2(TABLE_BUCKETS) : 1;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_RMW   = 3'd3;
    localparam logic [2:0] ST_SWEEP = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [AW:0] r_addr, n_addr;
    t_req        r_req;
    logic [AW-1:0] r_bucket;
    logic [80:0] r_result;
    logic        r_enable;
    logic [30:0] r_inf;
    logic [31:0] r_mid_lo, r_mid_hi;

    logic [BUCKET_W-1:0] ram_rdata, ram_wdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr, ram_raddr;
    t_slot rd_deep, rd_new, wr_deep, wr_new, sw_deep, sw_new;
    logic        rmw_write;
    logic [80:0] rmw_result;
    logic [11:0] in_bucket;
    logic signed [31:0] inf_s;

    assign in_bucket = s_axis_tdata[14:3];
    assign {rd_deep, rd_new} = ram_rdata;
    assign inf_s = {1'b0, r_inf};

    tst_bucket_logic u_logic (
        .i_req    (r_req),
        .i_deep   (rd_deep),
        .i_new    (rd_new),
        .i_enable (r_enable),
        .i_inf    (r_inf),
        .o_deep   (wr_deep),
        .o_new    (wr_new),
        .o_write  (rmw_write),
        .o_result (rmw_result)
    );

    tst_ram #(.WIDTH(BUCKET_W), .DEPTH(TABLE_BUCKETS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sweep: bound resets rewrite each bucket from its previous contents; clear zeroes it
    always_comb begin
        sw_deep = rd_deep;
        sw_new  = rd_new;
        case (r_req.command)
            CMD_RST_MID: begin
                sw_deep.lower = r_mid_lo; sw_deep.upper = r_mid_hi;
                sw_new.lower  = r_mid_lo; sw_new.upper  = r_mid_hi;
            end
            CMD_RST_WL: begin
                sw_deep.lower = -inf_s; sw_deep.upper = inf_s;
                sw_new.lower  = -inf_s; sw_new.upper  = inf_s;
            end
            CMD_RST_EXACT: begin
                sw_deep.lower = -inf_s; sw_deep.upper = inf_s;
                sw_new.lower  = -inf_s; sw_new.upper  = inf_s;
                sw_deep.empties = EXACT_EMPTIES;
                sw_new.empties  = EXACT_EMPTIES;
            end
            default: begin
                sw_deep = '0;
                sw_new  = '0;
            end
        endcase
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = (r_state == ST_OUT);
    assign m_axis_tdata  = {7'd0, r_result};

    // read address runs one ahead of the write address during the sweep
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        ram_we    = 1'b0;
        ram_waddr = r_addr[AW-1:0];
        ram_wdata = '0;
        ram_raddr = r_bucket;
        case (r_state)
            ST_INIT: begin
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == (AW+1)'(TABLE_BUCKETS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ram_raddr = in_bucket[AW-1:0];
                n_addr    = '0;
                if (s_axis_tvalid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_req.command == CMD_LOOKUP || r_req.command == CMD_UPDATE) begin
                    n_state = ST_RMW;
                end else if (r_req.command == CMD_CLEAR || r_req.command == CMD_RST_MID
                             || r_req.command == CMD_RST_WL
                             || r_req.command == CMD_RST_EXACT) begin
                    ram_raddr = '0;
                    n_state   = ST_SWEEP;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_RMW: begin
                ram_we    = rmw_write;
                ram_waddr = r_bucket;
                ram_wdata = {wr_deep, wr_new};
                n_state   = ST_OUT;
            end
            ST_SWEEP: begin
                ram_we    = 1'b1;
                ram_wdata = {sw_deep, sw_new};
                ram_raddr = AW'(r_addr + 1'b1);
                n_addr    = r_addr + 1'b1;
                if (r_addr == (AW+1)'(TABLE_BUCKETS - 1)) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_addr   <= '0;
            r_enable <= 1'b1;
            r_inf    <= 31'd30000;
            r_mid_lo <= -32'sd30000;
            r_mid_hi <= 32'sd30000;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENABLE: r_enable <= i_cfg_data[0];
                    CFG_INF:    r_inf    <= i_cfg_data[30:0];
                    CFG_MID_LO: r_mid_lo <= i_cfg_data;
                    CFG_MID_HI: r_mid_hi <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && s_axis_tvalid) begin
            r_req <= '{command: s_axis_tdata[2:0], black: s_axis_tdata[78:15],
                       white: s_axis_tdata[142:79], alpha: s_axis_tdata[174:143],
                       beta: s_axis_tdata[206:175], score: s_axis_tdata[238:207],
                       empties: s_axis_tdata[245:239], move: s_axis_tdata[253:246]};
            r_bucket <= in_bucket[AW-1:0];
            r_result <= '0;
        end else if (r_state == ST_RMW) begin
            r_result <= rmw_result;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("accept while result pending");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RMW && r_req.command != CMD_LOOKUP) |=> m_axis_tdata == '0)
        else $error("nonzero result for non-lookup");

endmodule

`default_nettype wire

### sv/tst_ram.sv
// ----------------------------------------------------------------------------
// tst_ram: generic single-port-write, registered-read RAM
// One write and one read per cycle; read data is registered, valid in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module tst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### sv/tst_bucket_logic.sv
// ----------------------------------------------------------------------------
// tst_bucket_logic: bucket read-modify-write datapath
// Matches the key against both slots, narrows bounds, picks replacement,
// and builds the lookup result. Pure combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module tst_bucket_logic (
    input  wire tst_pkg::t_req   i_req,
    input  wire tst_pkg::t_slot  i_deep,
    input  wire tst_pkg::t_slot  i_new,
    input  wire             i_enable,
    input  wire [30:0]      i_inf,
    output tst_pkg::t_slot  o_deep,
    output tst_pkg::t_slot  o_new,
    output logic            o_write,
    output logic [80:0]     o_result
);
    import tst_pkg::*;

    logic               deep_hit, new_hit;
    logic signed [31:0] inf_s;
    logic signed [31:0] fr_lo, fr_hi;
    t_slot              fresh_slot;

    assign deep_hit = (i_deep.black == i_req.black) && (i_deep.white == i_req.white);
    assign new_hit  = (i_new.black == i_req.black) && (i_new.white == i_req.white);
    assign inf_s    = {1'b0, i_inf};

    always_comb begin
        fr_lo = (i_req.score > i_req.alpha) ? i_req.score : -inf_s;
        fr_hi = (i_req.score < i_req.beta) ? i_req.score : inf_s;
        fresh_slot = '{black: i_req.black, white: i_req.white, lower: fr_lo,
                       upper: fr_hi, move: i_req.move, empties: i_req.empties};
    end

    always_comb begin
        o_deep   = i_deep;
        o_new    = i_new;
        o_write  = 1'b0;
        o_result = '0;
        case (i_req.command)
            CMD_LOOKUP: begin
                if (deep_hit) begin
                    o_result = {i_deep.empties, i_deep.move, i_deep.upper,
                                i_deep.lower, 1'b0, 1'b1};
                end else if (new_hit) begin
                    o_result = {i_new.empties, i_new.move, i_new.upper,
                                i_new.lower, 1'b1, 1'b1};
                end
            end
            CMD_UPDATE: begin
                if (i_enable) begin
                    o_write = 1'b1;
                    if (deep_hit) begin
                        if (i_req.score < i_req.beta && i_req.score < i_deep.upper)
                            o_deep.upper = i_req.score;
                        if (i_req.score > i_req.alpha && i_req.score > i_deep.lower)
                            o_deep.lower = i_req.score;
                        o_deep.move = i_req.move;
                    end else if (new_hit) begin
                        if (i_req.score < i_req.beta && i_req.score < i_new.upper)
                            o_new.upper = i_req.score;
                        if (i_req.score > i_req.alpha && i_req.score > i_new.lower)
                            o_new.lower = i_req.score;
                        o_new.move = i_req.move;
                    end else if (i_deep.empties < i_req.empties) begin
                        if (i_new.empties < i_deep.empties) begin
                            o_new = i_deep;
                        end
                        o_deep = fresh_slot;
                    end else if (i_new.empties < i_req.empties) begin
                        o_new = fresh_slot;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### tb/tb_two_slot_transposition_table_unit.sv
// ----------------------------------------------------------------------------
// tb_two_slot_transposition_table_unit: transposition table unit testbench
// Drives lookup, update, bulk and unused-code requests over the request stream, predicts
// every response from a local copy of the table, and compares field by field.
// Register settings change between phases while the unit is idle.
// ----------------------------------------------------------------------------
module tb_two_slot_transposition_table_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import tst_pkg::*;

    localparam int BUCKETS = 4096;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic               found;
        logic               slot;
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        logic signed [7:0]  move;
        logic [6:0]         depth;
    } t_resp;

    typedef struct {
        logic [2:0]         cmd;
        logic [11:0]        idx;
        logic [63:0]        black;
        logic [63:0]        white;
        logic signed [31:0] alpha;
        logic signed [31:0] beta;
        logic signed [31:0] score;
        logic [6:0]         empties;
        logic signed [7:0]  move;
    } t_item;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic s_axis_tvalid = 0;
    logic s_axis_tready;
    logic [255:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 0;
    logic [87:0] m_axis_tdata;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_index = CFG_ENABLE;
    logic [31:0] i_cfg_data = '0;

    two_slot_transposition_table_unit dut (.*);

    always #5 i_clk = ~i_clk;

    // local copy of the table and registers
    t_slot deep_tab [BUCKETS];
    t_slot new_tab [BUCKETS];
    logic en_q;
    logic signed [31:0] inf_q, mid_lo_q, mid_hi_q;

    t_item pending_reqs [$];
    t_resp expected_resps [$];
    int errors = 0;
    int sent = 0, got = 0, idle_cycles = 0;
    bit stall_free = 0;
    bit hold_off = 0;
    int hold_count = 0;
    bit [7:0] cmd_seen = 0;
    bit in_fire = 0;

    task automatic report(input string what, input logic [127:0] got_v,
                          input logic [127:0] exp_v);
        errors++;
        $display("MISMATCH resp %0d %s: got %0h exp %0h", got, what, got_v, exp_v);
    endtask

    function automatic void narrow(inout t_slot s, input t_item it);
        if (it.score < it.beta && it.score < s.upper) s.upper = it.score;
        if (it.score > it.alpha && it.score > s.lower) s.lower = it.score;
    endfunction

    function automatic t_slot fresh_slot(input t_item it);
        t_slot s;
        s.black = it.black;
        s.white = it.white;
        s.empties = it.empties;
        s.move = it.move;
        s.lower = -inf_q;
        s.upper = inf_q;
        if (it.score < it.beta) s.upper = it.score;
        if (it.score > it.alpha) s.lower = it.score;
        return s;
    endfunction

    function automatic t_resp table_response(input t_item it);
        t_resp r;
        int k;
        k = it.idx;
        r = '0;
        case (it.cmd)
            CMD_LOOKUP: begin
                if (deep_tab[k].black == it.black && deep_tab[k].white == it.white) begin
                    r = {1'b1, 1'b0, deep_tab[k].lower, deep_tab[k].upper,
                         deep_tab[k].move, deep_tab[k].empties};
                end else if (new_tab[k].black == it.black &&
                             new_tab[k].white == it.white) begin
                    r = {1'b1, 1'b1, new_tab[k].lower, new_tab[k].upper,
                         new_tab[k].move, new_tab[k].empties};
                end
            end
            CMD_UPDATE: begin
                if (en_q) begin
                    if (deep_tab[k].black == it.black && deep_tab[k].white == it.white) begin
                        narrow(deep_tab[k], it);
                        deep_tab[k].move = it.move;
                    end else if (new_tab[k].black == it.black &&
                                 new_tab[k].white == it.white) begin
                        narrow(new_tab[k], it);
                        new_tab[k].move = it.move;
                    end else if (deep_tab[k].empties < it.empties) begin
                        if (new_tab[k].empties < deep_tab[k].empties) new_tab[k] = deep_tab[k];
                        deep_tab[k] = fresh_slot(it);
                    end else if (new_tab[k].empties < it.empties) begin
                        new_tab[k] = fresh_slot(it);
                    end
                end
            end
            CMD_CLEAR: begin
                for (int i = 0; i < BUCKETS; i++) begin
                    deep_tab[i] = '0;
                    new_tab[i] = '0;
                end
            end
            CMD_RST_MID, CMD_RST_WL, CMD_RST_EXACT: begin
                for (int i = 0; i < BUCKETS; i++) begin
                    deep_tab[i].lower = (it.cmd == CMD_RST_MID) ? mid_lo_q : -inf_q;
                    deep_tab[i].upper = (it.cmd == CMD_RST_MID) ? mid_hi_q : inf_q;
                    new_tab[i].lower = deep_tab[i].lower;
                    new_tab[i].upper = deep_tab[i].upper;
                    if (it.cmd == CMD_RST_EXACT) begin
                        deep_tab[i].empties = EXACT_EMPTIES;
                        new_tab[i].empties = EXACT_EMPTIES;
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // request handshake seen at the rising edge
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_fire) begin
                void'(pending_reqs.pop_front());
                sent++;
            end
            if (pending_reqs.size() > 0 && (stall_free || $urandom_range(99) >= 38)) begin
                t_item it;
                it = pending_reqs[0];
                s_axis_tvalid <= 1;
                s_axis_tdata <= {2'b0, it.move, it.empties, it.score, it.beta, it.alpha,
                                 it.white, it.black, it.idx, it.cmd};
            end else if (in_fire || !s_axis_tvalid) begin
                s_axis_tvalid <= 0;
            end
            if (hold_off) m_axis_tready <= 0;
            else m_axis_tready <= stall_free || $urandom_range(99) >= 38;
        end
    end

    // predictor feeds on accepted requests
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            t_item it;
            it.cmd = s_axis_tdata[2:0];
            it.idx = s_axis_tdata[14:3];
            it.black = s_axis_tdata[78:15];
            it.white = s_axis_tdata[142:79];
            it.alpha = s_axis_tdata[174:143];
            it.beta = s_axis_tdata[206:175];
            it.score = s_axis_tdata[238:207];
            it.empties = s_axis_tdata[245:239];
            it.move = s_axis_tdata[253:246];
            cmd_seen[it.cmd] = 1;
            expected_resps.push_back(table_response(it));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            t_resp r, e;
            r.found = m_axis_tdata[0];
            r.slot = m_axis_tdata[1];
            r.lower = m_axis_tdata[33:2];
            r.upper = m_axis_tdata[65:34];
            r.move = m_axis_tdata[73:66];
            r.depth = m_axis_tdata[80:74];
            if (expected_resps.size() == 0) begin
                report("unexpected", r, 0);
            end else begin
                e = expected_resps.pop_front();
                if (r.found !== e.found) report("found", r.found, e.found);
                if (r.slot !== e.slot) report("found_slot", r.slot, e.slot);
                if (r.lower !== e.lower) report("lower_bound", r.lower, e.lower);
                if (r.upper !== e.upper) report("upper_bound", r.upper, e.upper);
                if (r.move !== e.move) report("stored_move", r.move, e.move);
                if (r.depth !== e.depth) report("stored_depth", r.depth, e.depth);
            end
            got++;
        end
    end

    // watchdog: cycles with no request or response accepted
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: sent %0d, responses %0d", sent, got);
            $display("Verification failed");
            $finish;
        end
    end

    // long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            hold_off <= 1;
        end else begin
            hold_off <= 0;
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            CFG_ENABLE: en_q = val[0];
            CFG_INF:    inf_q = {1'b0, val[30:0]};
            CFG_MID_LO: mid_lo_q = val;
            default:    mid_hi_q = val;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_resps.size() > 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic t_item blank_item(input logic [2:0] cmd, input logic [11:0] idx);
        t_item it;
        it.cmd = cmd;
        it.idx = idx;
        it.black = '0;
        it.white = '0;
        it.alpha = 0;
        it.beta = 0;
        it.score = 0;
        it.empties = '0;
        it.move = '0;
        return it;
    endfunction

    // key pool keeps bucket hits frequent
    logic [63:0] key_black [8];
    logic [63:0] key_white [8];
    logic [11:0] hot_bucket [4];

    function automatic t_item random_item(input bit noisy);
        t_item it;
        int r, j;
        r = $urandom_range(99);
        if (r < 45) it.cmd = CMD_UPDATE;
        else if (r < 90) it.cmd = CMD_LOOKUP;
        else if (r < 92) it.cmd = CMD_CLEAR;
        else if (r < 94) it.cmd = CMD_RST_MID;
        else if (r < 96) it.cmd = CMD_RST_WL;
        else if (r < 98) it.cmd = CMD_RST_EXACT;
        else it.cmd = 3'($urandom_range(7));
        j = $urandom_range(7);
        if (noisy) begin
            it.idx = 12'($urandom);
            it.black = {$urandom, $urandom};
            it.white = {$urandom, $urandom};
        end else begin
            it.idx = hot_bucket[$urandom_range(3)];
            it.black = key_black[j];
            it.white = key_white[j];
        end
        it.alpha = $urandom;
        it.beta = $urandom;
        it.score = $urandom;
        if ($urandom_range(1)) begin
            it.alpha = $signed(12'($urandom)) - 2048;
            it.beta = $signed(12'($urandom)) - 1024;
            it.score = $signed(12'($urandom)) - 2048;
        end
        it.empties = 7'($urandom_range(64));
        it.move = 8'($urandom);
        return it;
    endfunction

    initial begin
        int n;
        t_item it;
        en_q = 1;
        inf_q = 30000;
        mid_lo_q = -30000;
        mid_hi_q = 30000;
        for (int i = 0; i < BUCKETS; i++) begin
            deep_tab[i] = '0;
            new_tab[i] = '0;
        end
        for (int i = 0; i < 8; i++) begin
            key_black[i] = {$urandom, $urandom};
            key_white[i] = {$urandom, $urandom};
        end
        key_black[0] = '0;
        key_white[0] = '0;
        key_black[1] = '1;
        key_white[1] = '1;
        for (int i = 0; i < 4; i++) hot_bucket[i] = 12'($urandom);
        hot_bucket[0] = 0;
        hot_bucket[1] = 12'hFFF;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;

        // directed: empty-key hit, replacement, narrowing, bulk commands, unused codes
        pending_reqs.push_back(blank_item(CMD_LOOKUP, 0));
        it = blank_item(CMD_UPDATE, 12'hFFF);
        it.black = '1; it.white = '1; it.empties = 64; it.move = -128;
        it.alpha = 32'sh80000000; it.beta = 32'sh7FFFFFFF; it.score = 5;
        pending_reqs.push_back(it);
        it.black = 64'h1; it.empties = 10; it.move = 127; it.score = 32'sh80000000;
        pending_reqs.push_back(it);
        it.black = 64'h2; it.empties = 10;
        pending_reqs.push_back(it);
        it.black = 64'h3; it.empties = 64;
        pending_reqs.push_back(it);
        it.black = '1; it.alpha = -100; it.beta = 100; it.score = 50; it.empties = 0;
        pending_reqs.push_back(it);
        it.score = 32'sh7FFFFFFF;
        pending_reqs.push_back(it);
        it.cmd = CMD_LOOKUP;
        pending_reqs.push_back(it);
        it.black = 64'h1;
        pending_reqs.push_back(it);
        it.black = 64'h3;
        pending_reqs.push_back(it);
        pending_reqs.push_back(blank_item(CMD_RST_MID, 7));
        pending_reqs.push_back(blank_item(CMD_RST_WL, 0));
        pending_reqs.push_back(blank_item(CMD_RST_EXACT, 0));
        pending_reqs.push_back(blank_item(3'd6, 0));
        pending_reqs.push_back(blank_item(3'd7, 0));
        pending_reqs.push_back(blank_item(CMD_LOOKUP, 0));
        pending_reqs.push_back(blank_item(CMD_CLEAR, 0));
        pending_reqs.push_back(blank_item(CMD_LOOKUP, 0));
        wait_drained();

        // register phases, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_INF, 32'h7FFFFFFF);
                    cfg_write(CFG_MID_LO, 32'h80000000);
                    cfg_write(CFG_MID_HI, 32'h7FFFFFFF);
                end
                1: begin
                    cfg_write(CFG_ENABLE, 0);
                    cfg_write(CFG_INF, 0);
                end
                2: begin
                    cfg_write(CFG_ENABLE, 1);
                    cfg_write(CFG_MID_LO, 32'h7FFFFFFF);
                    cfg_write(CFG_MID_HI, 32'h80000000);
                end
                3: begin
                    cfg_write(CFG_INF, $urandom);
                    cfg_write(CFG_MID_LO, $urandom);
                    cfg_write(CFG_MID_HI, $urandom);
                end
                default: begin
                    cfg_write(CFG_INF, 30000);
                    cfg_write(CFG_MID_LO, -30000);
                    cfg_write(CFG_MID_HI, 30000);
                end
            endcase
            stall_free = (ph == 2);
            n = (ph == 1) ? 40 : 100;
            for (int i = 0; i < n; i++) pending_reqs.push_back(random_item($urandom_range(9) == 0));
            if (ph == 3) begin
                // receiver blocked while requests keep coming
                hold_count = 300;
            end
            wait_drained();
        end

        $display("Covered %0d requests, %0d responses, command mask %b, five register phases",
                 sent, got, cmd_seen);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
